FILE: rtl/core/tmb_pkg.sv
// Shared types and constants for the temporal median background block.
`timescale 1ns / 1ps
package tmb_pkg;

  localparam int DATA_W = 8;

  // Link that each sorting cell hands to its upper neighbor.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              gt;
    logic              occ;
  } tmb_link_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } tmb_state_t;

endpackage

FILE: rtl/core/temporal_median_background_top.sv
// Top level of the temporal median background block.
`timescale 1ns / 1ps
// Temporal median background for one pixel position at a time. Each request
// carries one 8-bit gray sample of the pixel in one frame, plus a last flag
// on the final frame. Samples are kept in ascending order in a chain of
// MAX_FRAMES sorting cells: every cell compares the incoming sample with its
// own value in parallel and either keeps its value, takes the value of its
// lower neighbor, or takes the new sample, so one sample enters per cycle
// outside the emit state. A sample with the last flag is inserted, and then
// in the emit state the element at index floor(n/2) (the upper middle for
// even n) is loaded into the output register together with the overflow
// flag, after which the count is cleared for the next pixel. Samples
// arriving while MAX_FRAMES are already held are dropped and flag overflow
// on that pixel's result. The output register lets the next pixel's samples
// flow in while a result still waits to be taken; the emit cycle stalls
// only if the previous result has not been taken yet.
module temporal_median_background_top
  import tmb_pkg::*;
#(
  parameter int MAX_FRAMES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] sample,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] median,
  output logic              overflow
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  tmb_state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ovf, ovf_next;
  logic             out_valid_next;
  logic             load_out;
  logic             accept;
  logic             full;
  logic             insert;
  logic [IDX_W-1:0] mid;
  logic [CNT_W-1:0] half;

  tmb_link_t        links [MAX_FRAMES];
  logic [DATA_W-1:0] cell_data [MAX_FRAMES];

  assign accept = in_valid && in_ready;
  assign full   = (cnt == CNT_W'(MAX_FRAMES));
  assign insert = accept && !full;

  // The sorting chain. Cell 0 sees a lower neighbor that is occupied and
  // never larger, so it takes the sample whenever it is the insertion point.
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    tmb_link_t prev;
    logic      occ;

    assign occ = (CNT_W'(i) < cnt);

    if (i == 0) begin : g_first
      assign prev = '{data: '0, gt: 1'b0, occ: 1'b1};
    end else begin : g_rest
      assign prev = links[i-1];
    end

    tmb_cell u_cell (
      .clk    (clk),
      .insert (insert),
      .value  (sample),
      .occ    (occ),
      .prev   (prev),
      .link   (links[i])
    );

    assign cell_data[i] = links[i].data;
  end

  // The count is never zero in the emit cycle, and half of it stays below
  // the capacity.
  assign half = cnt >> 1;
  assign mid  = half[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median   <= cell_data[mid];
      overflow <= ovf;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ovf_next       = ovf;
    out_valid_next = out_valid && !out_ready;
    load_out       = 1'b0;
    in_ready       = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (accept) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
          if (last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Wait until the output register is free, then take the median
        // and start the next pixel.
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          cnt_next       = '0;
          ovf_next       = 1'b0;
          state_next     = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

endmodule

FILE: rtl/core/tmb_cell.sv
// One cell of the insertion-sort chain: holds one sorted sample.
`timescale 1ns / 1ps
module tmb_cell
  import tmb_pkg::*;
(
  input  logic              clk,
  input  logic              insert,
  input  logic [DATA_W-1:0] value,
  input  logic              occ,
  input  tmb_link_t         prev,
  output tmb_link_t         link
);

  logic [DATA_W-1:0] data;
  logic              gt;

  assign gt = occ && (data > value);

  always_ff @(posedge clk) begin
    if (insert) begin
      // The cell below shifts up when it holds a larger value; otherwise
      // this cell takes the new sample if it is the insertion point.
      if (prev.gt) begin
        data <= prev.data;
      end else if (gt || (!occ && prev.occ)) begin
        data <= value;
      end
    end
  end

  assign link.data = data;
  assign link.gt   = gt;
  assign link.occ  = occ;

endmodule

FILE: test/tb_temporal_median_background_top.sv
// Self-checking testbench for the temporal median background block.
`timescale 1ns / 1ps
// The testbench streams pixels into the block, one gray sample per request,
// with the last flag on the final sample of each pixel. A small scoreboard
// keeps its own sorted copy of the current pixel's samples. On every accepted
// last request it queues the expected median and overflow flag. Each accepted
// result is compared with the oldest queued expectation.
//
// The stimulus starts with a few hand-picked pixels:
//   - single-sample pixels at both ends of the range,
//   - even-sized pixels, where the upper middle value is expected,
//   - pixels with repeated values.
// Random pixels follow. Most of them are short. Some are sized to fill the
// sorting chain exactly, and some overrun it so that samples are dropped,
// the last one among them. Both sides pause in random bursts, except in
// stretches of calm and in the final part of the run.
module tb_temporal_median_background_top;
  import tmb_pkg::*;

  localparam int MAX_FRAMES   = 32;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_TAIL    = 150;   // requests at the end with no idling
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [DATA_W-1:0] median;
    logic              overflow;
  } background_t;

  // Keeps the samples of the pixel in progress in ascending order. It also
  // holds the backgrounds that the block still owes.
  class median_scoreboard;
    logic [DATA_W-1:0] held_samples[$];
    bit                samples_dropped;
    background_t       owed_backgrounds[$];
    int                errors;

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // One accepted input request. A full chain drops the sample. A sample
    // equal to held values goes above them.
    function void note_request(logic [DATA_W-1:0] value, logic is_last);
      int          pos;
      background_t bg;
      if (held_samples.size() < MAX_FRAMES) begin
        pos = held_samples.size();
        while (pos > 0 && held_samples[pos-1] > value) pos--;
        held_samples.insert(pos, value);
      end else begin
        samples_dropped = 1'b1;
      end
      if (is_last) begin
        bg.median   = held_samples[held_samples.size() / 2];
        bg.overflow = samples_dropped;
        owed_backgrounds.insert(owed_backgrounds.size(), bg);
        held_samples.delete();
        samples_dropped = 1'b0;
      end
    endfunction

    // One accepted result request, compared field by field with the oldest
    // expectation.
    function void check_result(logic [DATA_W-1:0] median, logic overflow);
      background_t bg;
      if (owed_backgrounds.size() == 0) begin
        flag_error($sformatf("result median=%0d overflow=%0b with no pixel pending",
                             median, overflow));
        return;
      end
      bg = owed_backgrounds.pop_front();
      if (median !== bg.median)
        flag_error($sformatf("median expected %0d, got %0d", bg.median, median));
      if (overflow !== bg.overflow)
        flag_error($sformatf("overflow expected %0b, got %0b", bg.overflow, overflow));
    endfunction

    function int pending();
      return owed_backgrounds.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] sample;
  logic              last;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] median;
  logic              overflow;

  median_scoreboard sb = new();
  bit               idle_on;
  int               items_sent;
  int               quiet_cycles;

  temporal_median_background_top #(
    .MAX_FRAMES(MAX_FRAMES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .last     (last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .median   (median),
    .overflow (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge. The stimulus changes only
  // at falling edges, so the values seen here are settled. The result is
  // checked before the input is noted, because a result can never come
  // from a request accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(median, overflow);
      if (in_valid && in_ready) sb.note_request(sample, last);
    end
  end

  // The watchdog counts edges at which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("tb_temporal_median_background_top failed");
        $finish;
      end
    end
  end

  // The receiver holds ready low in random bursts while idling is enabled.
  // Each branch makes its one assignment at a falling edge.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // This task starts and ends at a falling edge. Valid goes high and then
  // waits, unchanged, for the edge where ready is high. When one request
  // follows another, valid stays high unless a random idle pause drops it.
  task automatic send_request(input logic [DATA_W-1:0] value, input logic is_last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    last     <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // A random pixel of the given length. The value spread is chosen per
  // pixel: the full range, a narrow band full of repeats, or only the two
  // extremes.
  task automatic send_random_pixel(input int len);
    int                spread;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] value;
    spread = $urandom_range(0, 3);
    base   = DATA_W'($urandom_range(0, 251));
    for (int i = 0; i < len; i++) begin
      case (spread)
        0: value = base + DATA_W'($urandom_range(0, 3));
        1: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: value = DATA_W'($urandom_range(0, 255));
      endcase
      send_request(value, i == len - 1);
    end
  endtask

  initial begin
    int len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    sample     = '0;
    last       = 1'b0;
    idle_on    = 1'b1;
    items_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-sample pixels at both ends of the range.
    send_request(8'd0, 1'b1);
    send_request(8'd255, 1'b1);
    // Two samples: the upper of the middle pair is expected.
    send_request(8'd10, 1'b0);
    send_request(8'd20, 1'b1);
    // Four samples given out of order.
    send_request(8'd200, 1'b0);
    send_request(8'd100, 1'b0);
    send_request(8'd50, 1'b0);
    send_request(8'd150, 1'b1);
    // Repeated values around a smaller one.
    send_request(8'd7, 1'b0);
    send_request(8'd7, 1'b0);
    send_request(8'd3, 1'b0);
    send_request(8'd7, 1'b0);
    send_request(8'd7, 1'b1);
    // Descending extremes with a middle value.
    send_request(8'd255, 1'b0);
    send_request(8'd128, 1'b0);
    send_request(8'd0, 1'b1);

    // Three pixels around the capacity first. One fills the chain exactly.
    // In the next, the last sample alone is dropped. The third overruns by
    // several samples.
    send_random_pixel(MAX_FRAMES);
    send_random_pixel(MAX_FRAMES + 1);
    send_random_pixel(MAX_FRAMES + 8);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(MAX_FRAMES - 4, MAX_FRAMES);
        1:       len = $urandom_range(MAX_FRAMES + 1, MAX_FRAMES + 8);
        2:       len = $urandom_range(10, MAX_FRAMES - 5);
        default: len = $urandom_range(1, 9);
      endcase
      send_random_pixel(len);
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    // Wait for every owed background. The watchdog catches one that never
    // comes. A drain wait then catches any result nobody asked for.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_temporal_median_background_top passed");
    end else begin
      $display("tb_temporal_median_background_top failed");
    end
    $finish;
  end

endmodule
